>>> design/assert_macros.svh
// assertion macros for the page hash index
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define VPHI_ASSERT_IMP(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
    else $error("assertion failed");
`define VPHI_ASSERT_NXT(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
    else $error("assertion failed");
`else
`define VPHI_ASSERT_IMP(lbl, ant, con)
`define VPHI_ASSERT_NXT(lbl, ant, con)
`endif
`endif

>>> design/vphi_pkg.sv
// shared types and constants for the page hash index
package vphi_pkg;

  localparam int unsigned SLOTS_DEF = 1024;
  localparam logic [31:0] HASH_BASIS = 32'd2166136261;
  localparam logic [31:0] HASH_PRIME = 32'd16777619;
  localparam logic [10:0] TABLE_SIZE_RST = 11'd1024;

  typedef enum logic [2:0] {
    CMD_PUBLISH    = 3'd0,
    CMD_FIND       = 3'd1,
    CMD_CLEAR      = 3'd2,
    CMD_REQ_SCAN   = 3'd3,
    CMD_INVALIDATE = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_SCAN      = 2'd2,
    ST_ERROR     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_HASH,
    S_RD,
    S_CHK,
    S_SWEEP,
    S_DONE
  } state_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] space;
    logic [31:0] page;
    logic [63:0] commit;
    logic [63:0] plsn;
    logic [63:0] offset;
  } slot_t;

endpackage

>>> design/vphi_slot_ram.sv
// slot store: one write port, one registered read port
module vphi_slot_ram #(
  parameter int unsigned DEPTH = vphi_pkg::SLOTS_DEF,
  parameter int unsigned AW    = 10
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  vphi_pkg::slot_t      wdata,
  input  logic [AW-1:0]        raddr,
  output vphi_pkg::slot_t      rdata_r
);

  vphi_pkg::slot_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

>>> design/vphi_hash_mod.sv
// fnv-1a key hash and iterative remainder by the table size
module vphi_hash_mod #(
  parameter int unsigned AW = 10,
  parameter int unsigned NW = 11
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [31:0]   key_space,
  input  logic [31:0]   page_no,
  input  logic [NW-1:0] n,
  output logic          done,
  output logic [AW-1:0] pos
);

  localparam int unsigned RW = NW + 1;

  logic          busy_r, busy_nxt;
  logic [5:0]    cnt_r, cnt_nxt;
  logic [31:0]   h_r, h_nxt;
  logic [RW-1:0] rem_r, rem_nxt;
  logic [RW-1:0] rem_sh;
  logic [31:0]   mul_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    h_r   <= h_nxt;
    rem_r <= rem_nxt;
  end

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    h_nxt    = h_r;
    rem_nxt  = rem_r;
    done     = 1'b0;
    mul_a    = (cnt_r == 6'd0) ? h_r : (h_r ^ page_no);
    rem_sh   = {rem_r[RW-2:0], h_r[31]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      h_nxt    = vphi_pkg::HASH_BASIS ^ key_space;
      rem_nxt  = '0;
    end else if (busy_r) begin
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r < 6'd2) begin
        h_nxt = 32'(mul_a * vphi_pkg::HASH_PRIME);
      end else begin
        h_nxt = {h_r[30:0], 1'b0};
        if (rem_sh >= RW'(n)) begin
          rem_nxt = rem_sh - RW'(n);
        end else begin
          rem_nxt = rem_sh;
        end
      end
      if (cnt_r == 6'd33) begin
        busy_nxt = 1'b0;
        done     = 1'b1;
      end
    end
  end

  // final remainder step is visible in the done cycle
  assign pos = rem_nxt[AW-1:0];

endmodule

>>> design/versioned_page_hash_index.sv
// top level of the versioned page hash index
// Usage: commands arrive on the in_ channel (valid/ready), one result per
// command leaves on the out_ channel (valid/ready). cfg_wr_en writes the
// table size at once; write it only while the block is idle.
// Publish and find hash the key (two multiplies, then a remainder of the
// 32-bit hash by the table size), then probe one slot at a time, a read
// state then a check state, through the slot memory read port. Clear and
// invalidate sweep the slots in use, one a cycle through the write port.
// Require scan and operand errors go straight to the result register.
// One command is in flight at a time; in_ready is high only when idle.
// After reset all SLOTS slots of the slot memory are swept empty, and no
// command is taken meanwhile.
// A finished result sits in the output register until the receiver takes
// it; the next command may be accepted while it waits, and its own result
// is held back until the output register is free.
`include "assert_macros.svh"
module versioned_page_hash_index #(
  parameter int unsigned SLOTS = vphi_pkg::SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [10:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_cmd,
  input  logic [31:0] in_tablespace,
  input  logic [31:0] in_page_no,
  input  logic [63:0] in_commit_lsn,
  input  logic [63:0] in_page_lsn,
  input  logic [63:0] in_record_offset,
  input  logic [63:0] in_max_commit_lsn,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [63:0] out_found_record_offset,
  output logic [63:0] out_found_page_lsn,
  output logic [63:0] out_found_commit_lsn,
  output logic [63:0] out_generation
);

  localparam int unsigned AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned NW = $clog2(SLOTS + 1);

  vphi_pkg::state_t state_r, state_nxt;
  logic [10:0]      ts_r;
  logic [NW-1:0]    n;
  logic [AW-1:0]    pos_r, pos_nxt, pos_inc, sweep_last_r, sweep_last_nxt;
  logic [NW-1:0]    k_r, k_nxt;
  logic             last_k;
  logic [2:0]       cmd_r, cmd_nxt;
  logic [31:0]      sp_r, pg_r;
  logic [63:0]      c_r, p_r, o_r, lim_r;
  logic             scan_r, scan_nxt, trust_r, trust_nxt;
  logic [63:0]      gen_r, gen_nxt;
  logic             have_r, have_nxt, present_r, present_nxt;
  logic [63:0]      bc_r, bc_nxt, bp_r, bp_nxt, bo_r, bo_nxt;
  logic [1:0]       res_st_r, res_st_nxt;
  logic [63:0]      res_off_r, res_off_nxt, res_plsn_r, res_plsn_nxt;
  logic [63:0]      res_commit_r, res_commit_nxt, res_gen_r, res_gen_nxt;
  logic             out_valid_r;
  logic [1:0]       out_st_r;
  logic [63:0]      out_off_r, out_plsn_r, out_commit_r, out_gen_r;
  logic             load_out;
  logic             in_xfer;
  logic             gen_max;
  logic             key_hit;
  logic             h_start, h_done;
  logic [AW-1:0]    h_pos;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  vphi_pkg::slot_t  ram_wdata, rd;

  vphi_hash_mod #(.AW(AW), .NW(NW)) u_hash (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (h_start),
    .key_space (in_tablespace),
    .page_no   (pg_r),
    .n         (n),
    .done      (h_done),
    .pos       (h_pos)
  );

  vphi_slot_ram #(.DEPTH(SLOTS), .AW(AW)) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr   (pos_r),
    .rdata_r (rd)
  );

  always_comb begin
    if (ts_r == 11'd0) begin
      n = NW'(1);
    end else if (32'(ts_r) > 32'(SLOTS)) begin
      n = NW'(SLOTS);
    end else begin
      n = NW'(ts_r);
    end
  end

  assign in_ready = (state_r == vphi_pkg::S_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign gen_max  = &gen_r;
  assign last_k   = (NW'(k_r + NW'(1)) == n);
  assign pos_inc  = (NW'(NW'(pos_r) + NW'(1)) == n) ? '0 : AW'(pos_r + AW'(1));
  assign key_hit  = (rd.space == sp_r) && (rd.page == pg_r);
  assign load_out = (state_r == vphi_pkg::S_DONE) && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= vphi_pkg::S_INIT;
      ts_r        <= vphi_pkg::TABLE_SIZE_RST;
      pos_r       <= '0;
      sweep_last_r <= AW'(SLOTS - 1);
      scan_r      <= 1'b0;
      trust_r     <= 1'b0;
      gen_r       <= 64'd1;
      out_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      pos_r        <= pos_nxt;
      sweep_last_r <= sweep_last_nxt;
      scan_r       <= scan_nxt;
      trust_r      <= trust_nxt;
      gen_r        <= gen_nxt;
      if (cfg_wr_en) begin
        ts_r <= cfg_wr_data;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    k_r          <= k_nxt;
    cmd_r        <= cmd_nxt;
    have_r       <= have_nxt;
    present_r    <= present_nxt;
    bc_r         <= bc_nxt;
    bp_r         <= bp_nxt;
    bo_r         <= bo_nxt;
    res_st_r     <= res_st_nxt;
    res_off_r    <= res_off_nxt;
    res_plsn_r   <= res_plsn_nxt;
    res_commit_r <= res_commit_nxt;
    res_gen_r    <= res_gen_nxt;
    if (in_xfer) begin
      sp_r  <= in_tablespace;
      pg_r  <= in_page_no;
      c_r   <= in_commit_lsn;
      p_r   <= in_page_lsn;
      o_r   <= in_record_offset;
      lim_r <= in_max_commit_lsn;
    end
    if (load_out) begin
      out_st_r     <= res_st_r;
      out_off_r    <= res_off_r;
      out_plsn_r   <= res_plsn_r;
      out_commit_r <= res_commit_r;
      out_gen_r    <= res_gen_r;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    pos_nxt        = pos_r;
    sweep_last_nxt = sweep_last_r;
    k_nxt          = k_r;
    cmd_nxt        = cmd_r;
    scan_nxt       = scan_r;
    trust_nxt      = trust_r;
    gen_nxt        = gen_r;
    have_nxt       = have_r;
    present_nxt    = present_r;
    bc_nxt         = bc_r;
    bp_nxt         = bp_r;
    bo_nxt         = bo_r;
    res_st_nxt     = res_st_r;
    res_off_nxt    = res_off_r;
    res_plsn_nxt   = res_plsn_r;
    res_commit_nxt = res_commit_r;
    res_gen_nxt    = res_gen_r;
    h_start        = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = pos_r;
    ram_wdata      = '0;
    unique case (state_r)
      vphi_pkg::S_INIT, vphi_pkg::S_SWEEP: begin
        ram_we = 1'b1;
        if (pos_r == sweep_last_r) begin
          pos_nxt   = '0;
          state_nxt = (state_r == vphi_pkg::S_INIT) ? vphi_pkg::S_IDLE : vphi_pkg::S_DONE;
        end else begin
          pos_nxt = AW'(pos_r + AW'(1));
        end
      end
      vphi_pkg::S_IDLE: begin
        if (in_xfer) begin
          cmd_nxt        = in_cmd;
          res_st_nxt     = vphi_pkg::ST_ERROR;
          res_off_nxt    = '0;
          res_plsn_nxt   = '0;
          res_commit_nxt = '0;
          res_gen_nxt    = '0;
          have_nxt       = 1'b0;
          present_nxt    = 1'b0;
          pos_nxt        = '0;
          sweep_last_nxt = AW'(n - NW'(1));
          state_nxt      = vphi_pkg::S_DONE;
          unique case (in_cmd)
            vphi_pkg::CMD_PUBLISH: begin
              if (in_commit_lsn != '0 && in_page_lsn != '0 &&
                  in_record_offset != '0 && !gen_max) begin
                h_start   = 1'b1;
                state_nxt = vphi_pkg::S_HASH;
              end
            end
            vphi_pkg::CMD_FIND: begin
              if (in_max_commit_lsn != '0) begin
                res_gen_nxt = gen_r;
                h_start     = 1'b1;
                state_nxt   = vphi_pkg::S_HASH;
              end
            end
            vphi_pkg::CMD_CLEAR: begin
              if (!gen_max) begin
                scan_nxt   = 1'b0;
                trust_nxt  = 1'b0;
                gen_nxt    = gen_r + 64'd1;
                res_st_nxt = vphi_pkg::ST_OK;
                state_nxt  = vphi_pkg::S_SWEEP;
              end
            end
            vphi_pkg::CMD_REQ_SCAN: begin
              if (!gen_max) begin
                scan_nxt   = 1'b1;
                trust_nxt  = 1'b0;
                gen_nxt    = gen_r + 64'd1;
                res_st_nxt = vphi_pkg::ST_OK;
              end
            end
            vphi_pkg::CMD_INVALIDATE: begin
              scan_nxt   = 1'b1;
              trust_nxt  = 1'b0;
              gen_nxt    = gen_max ? gen_r : gen_r + 64'd1;
              res_st_nxt = vphi_pkg::ST_OK;
              state_nxt  = vphi_pkg::S_SWEEP;
            end
            default: ;
          endcase
        end
      end
      vphi_pkg::S_HASH: begin
        if (h_done) begin
          pos_nxt   = h_pos;
          k_nxt     = '0;
          state_nxt = vphi_pkg::S_RD;
        end
      end
      vphi_pkg::S_RD: begin
        state_nxt = vphi_pkg::S_CHK;
      end
      vphi_pkg::S_CHK: begin
        pos_nxt   = pos_inc;
        k_nxt     = NW'(k_r + NW'(1));
        state_nxt = vphi_pkg::S_RD;
        if (cmd_r == vphi_pkg::CMD_PUBLISH) begin
          ram_wdata = '{valid: 1'b1, space: sp_r, page: pg_r,
                        commit: c_r, plsn: p_r, offset: o_r};
          if (!rd.valid) begin
            ram_we     = 1'b1;
            gen_nxt    = gen_r + 64'd1;
            res_st_nxt = vphi_pkg::ST_OK;
            state_nxt  = vphi_pkg::S_DONE;
          end else if (key_hit) begin
            if ({c_r, p_r, o_r} > {rd.commit, rd.plsn, rd.offset}) begin
              ram_we  = 1'b1;
              gen_nxt = gen_r + 64'd1;
            end
            res_st_nxt = vphi_pkg::ST_OK;
            state_nxt  = vphi_pkg::S_DONE;
          end else if (last_k) begin
            trust_nxt  = trust_r || !scan_r;
            scan_nxt   = 1'b1;
            gen_nxt    = gen_r + 64'd1;
            res_st_nxt = vphi_pkg::ST_OK;
            state_nxt  = vphi_pkg::S_DONE;
          end
        end else begin
          if (rd.valid && key_hit) begin
            present_nxt = 1'b1;
            if (rd.commit <= lim_r &&
                (!have_r || {rd.commit, rd.plsn, rd.offset} > {bc_r, bp_r, bo_r})) begin
              have_nxt = 1'b1;
              bc_nxt   = rd.commit;
              bp_nxt   = rd.plsn;
              bo_nxt   = rd.offset;
            end
          end
          if (!rd.valid || last_k) begin
            state_nxt = vphi_pkg::S_DONE;
            if (scan_r && !trust_r) begin
              res_st_nxt = vphi_pkg::ST_SCAN;
            end else if (have_nxt) begin
              res_st_nxt     = vphi_pkg::ST_OK;
              res_off_nxt    = bo_nxt;
              res_plsn_nxt   = bp_nxt;
              res_commit_nxt = bc_nxt;
            end else if (present_nxt || scan_r) begin
              res_st_nxt = vphi_pkg::ST_SCAN;
            end else begin
              res_st_nxt = vphi_pkg::ST_NOT_FOUND;
            end
          end
        end
      end
      vphi_pkg::S_DONE: begin
        if (load_out) begin
          state_nxt = vphi_pkg::S_IDLE;
        end
      end
      default: state_nxt = vphi_pkg::S_IDLE;
    endcase
  end

  assign out_valid               = out_valid_r;
  assign out_status              = out_st_r;
  assign out_found_record_offset = out_off_r;
  assign out_found_page_lsn      = out_plsn_r;
  assign out_found_commit_lsn    = out_commit_r;
  assign out_generation          = out_gen_r;

  `VPHI_ASSERT_NXT(a_busy_after_xfer, in_valid && in_ready, !in_ready)
  `VPHI_ASSERT_IMP(a_gen_nonzero, 1'b1, gen_r != 64'd0)
  `VPHI_ASSERT_IMP(a_found_only_ok, out_valid && out_status != vphi_pkg::ST_OK, out_found_commit_lsn == 64'd0)

endmodule
